@@ hw/rtl/mbtf_pkg.sv @@
// constants and types for the modbus tcp request framer
// no dependencies; used by modbus_tcp_request_framer
package mbtf_pkg;

    // request modes of an input item
    localparam logic [3:0] MODE_RD_COILS  = 4'd0;
    localparam logic [3:0] MODE_RD_INPUTS = 4'd1;
    localparam logic [3:0] MODE_RD_HOLD   = 4'd2;
    localparam logic [3:0] MODE_RD_INREGS = 4'd3;
    localparam logic [3:0] MODE_WR_COIL   = 4'd4;
    localparam logic [3:0] MODE_WR_REG    = 4'd5;
    localparam logic [3:0] MODE_WR_COILS  = 4'd6;
    localparam logic [3:0] MODE_WR_REGS   = 4'd7;
    localparam logic [3:0] MODE_DATA      = 4'd8;

    // function codes
    localparam logic [7:0] FN_WR_COIL  = 8'd5;
    localparam logic [7:0] FN_WR_REG   = 8'd6;
    localparam logic [7:0] FN_WR_COILS = 8'd15;
    localparam logic [7:0] FN_WR_REGS  = 8'd16;

    localparam logic [15:0] COIL_ON      = 16'hFF00;
    localparam logic [15:0] LEN_SINGLE   = 16'd6;
    localparam logic [15:0] LEN_MULTI    = 16'd7;
    localparam logic [15:0] TID_RESET    = 16'd1;
    localparam logic [7:0]  UNIT_RESET   = 8'd1;

    localparam int unsigned DEF_MAX_WRITE_REGS  = 123;
    localparam int unsigned DEF_MAX_WRITE_COILS = 1968;
    localparam int unsigned DEF_MAX_READ_BITS   = 2040;

    localparam int unsigned FRAME_BYTES = 13;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_COILS = 2'd1,
        KIND_REGS  = 2'd2
    } t_kind;

    // bytes produced by one item, first byte at index 0
    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [3:0]                  cnt;
        logic                        last_end;
        logic                        rej;
    } t_frame;

endpackage

@@ hw/rtl/modbus_tcp_request_framer.sv @@
// modbus tcp request framer: turns request and data items into a byte stream
// depends on mbtf_pkg
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  request | in        | i_valid / o_stall         | i_mode i_address i_amount i_value
//  frame   | out       | o_valid / i_stall         | o_frame_byte o_frame_end o_rejected
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (unit id)
//
// one frame byte leaves per cycle through the output register while i_stall
// is low; an item yields 13 bytes for a multi-write header, 12 for a single
// frame, 2, 1 or 0 for a data item, 1 for a rejection.
// the frame for an item is built combinationally into a frame register, which
// takes the next item as soon as its last byte moves to the output register.
// reset is synchronous, active low; i_stall holds the output register.
module modbus_tcp_request_framer #(
    parameter int unsigned MAX_WRITE_REGS  = mbtf_pkg::DEF_MAX_WRITE_REGS,
    parameter int unsigned MAX_WRITE_COILS = mbtf_pkg::DEF_MAX_WRITE_COILS,
    parameter int unsigned MAX_READ_BITS   = mbtf_pkg::DEF_MAX_READ_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_mode,
    input  logic [15:0] i_address,
    input  logic [15:0] i_amount,
    input  logic [15:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end,
    output logic        o_rejected,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]           r_unit;
    logic [15:0]          r_tid;
    mbtf_pkg::t_kind      r_kind;
    logic [10:0]          r_rem;
    logic [7:0]           r_cbyte;
    logic [2:0]           r_cpos;

    logic [15:0]          n_tid;
    mbtf_pkg::t_kind      n_kind;
    logic [10:0]          n_rem;
    logic [7:0]           n_cbyte;
    logic [2:0]           n_cpos;
    mbtf_pkg::t_frame     n_frm;
    logic                 hdr_ok;

    logic                 r_fv;
    mbtf_pkg::t_frame     r_frm;
    logic [3:0]           r_fi;

    logic                 r_ov;
    logic [7:0]           r_ob;
    logic                 r_oe;
    logic                 r_or;

    logic                 out_load;
    logic                 slot_last;
    logic                 slot_free;
    logic                 in_acc;

    logic [15:0]          cnt16;
    logic [15:0]          len16;
    logic [7:0]           fn;
    logic [15:0]          word;
    logic [7:0]           coil_next;
    logic                 data_last;

    assign o_cfg_ready = 1'b1;

    assign out_load  = !r_ov || !i_stall;
    assign slot_last = (r_fi == (r_frm.cnt - 4'd1));
    assign slot_free = !r_fv || (out_load && slot_last);
    assign o_stall   = !slot_free;
    assign in_acc    = i_valid && slot_free;

    always_comb begin
        n_frm     = '0;
        n_tid     = r_tid;
        n_kind    = r_kind;
        n_rem     = r_rem;
        n_cbyte   = r_cbyte;
        n_cpos    = r_cpos;
        hdr_ok    = 1'b0;
        cnt16     = '0;
        len16     = mbtf_pkg::LEN_SINGLE;
        fn        = {4'd0, i_mode} + 8'd1;
        word      = i_amount;
        data_last = (r_rem == 11'd1);
        coil_next = r_cbyte | (8'(i_value[0]) << r_cpos);

        if (i_mode == mbtf_pkg::MODE_DATA) begin
            if (r_kind == mbtf_pkg::KIND_NONE || r_rem == 11'd0) begin
                n_frm.cnt = 4'd1; n_frm.last_end = 1'b1; n_frm.rej = 1'b1;
            end else begin
                n_rem = r_rem - 11'd1;
                if (data_last) begin
                    n_kind = mbtf_pkg::KIND_NONE;
                end
                n_frm.last_end = data_last;
                if (r_kind == mbtf_pkg::KIND_REGS) begin
                    n_frm.cnt      = 4'd2;
                    n_frm.bytes[0] = i_value[15:8];
                    n_frm.bytes[1] = i_value[7:0];
                end else if (r_cpos == 3'd7 || data_last) begin
                    n_frm.cnt      = 4'd1;
                    n_frm.bytes[0] = coil_next;
                    n_cbyte        = '0;
                    n_cpos         = '0;
                end else begin
                    n_cbyte = coil_next;
                    n_cpos  = r_cpos + 3'd1;
                end
            end
        end else begin
            hdr_ok = 1'b0;
            if (i_mode < mbtf_pkg::MODE_DATA && r_kind == mbtf_pkg::KIND_NONE) begin
                unique case (i_mode)
                    mbtf_pkg::MODE_RD_COILS, mbtf_pkg::MODE_RD_INPUTS: begin
                        hdr_ok = (i_amount <= 16'(MAX_READ_BITS));
                    end
                    mbtf_pkg::MODE_RD_HOLD, mbtf_pkg::MODE_RD_INREGS: begin
                        hdr_ok = 1'b1;
                    end
                    mbtf_pkg::MODE_WR_COIL: begin
                        hdr_ok = 1'b1;
                        fn     = mbtf_pkg::FN_WR_COIL;
                        word   = i_value[0] ? mbtf_pkg::COIL_ON : 16'd0;
                    end
                    mbtf_pkg::MODE_WR_REG: begin
                        hdr_ok = 1'b1;
                        fn     = mbtf_pkg::FN_WR_REG;
                        word   = i_value;
                    end
                    mbtf_pkg::MODE_WR_COILS: begin
                        hdr_ok = (i_amount != 16'd0) &&
                                 (i_amount <= 16'(MAX_WRITE_COILS));
                        fn     = mbtf_pkg::FN_WR_COILS;
                        cnt16  = 16'((17'(i_amount) + 17'd7) >> 3);
                        len16  = mbtf_pkg::LEN_MULTI + cnt16;
                    end
                    default: begin
                        hdr_ok = (i_amount != 16'd0) &&
                                 (i_amount <= 16'(MAX_WRITE_REGS));
                        fn     = mbtf_pkg::FN_WR_REGS;
                        cnt16  = {i_amount[14:0], 1'b0};
                        len16  = mbtf_pkg::LEN_MULTI + cnt16;
                    end
                endcase
            end
            if (!hdr_ok) begin
                n_frm.cnt = 4'd1; n_frm.last_end = 1'b1; n_frm.rej = 1'b1;
            end else begin
                n_frm.bytes[0]  = r_tid[15:8];
                n_frm.bytes[1]  = r_tid[7:0];
                n_frm.bytes[2]  = 8'd0;
                n_frm.bytes[3]  = 8'd0;
                n_frm.bytes[4]  = len16[15:8];
                n_frm.bytes[5]  = len16[7:0];
                n_frm.bytes[6]  = r_unit;
                n_frm.bytes[7]  = fn;
                n_frm.bytes[8]  = i_address[15:8];
                n_frm.bytes[9]  = i_address[7:0];
                n_frm.bytes[10] = word[15:8];
                n_frm.bytes[11] = word[7:0];
                n_frm.bytes[12] = cnt16[7:0];
                n_tid = r_tid + 16'd1;
                if (i_mode == mbtf_pkg::MODE_WR_COILS || i_mode == mbtf_pkg::MODE_WR_REGS) begin
                    n_frm.cnt      = 4'd13;
                    n_frm.last_end = 1'b0;
                    n_kind  = (i_mode == mbtf_pkg::MODE_WR_COILS) ?
                              mbtf_pkg::KIND_COILS : mbtf_pkg::KIND_REGS;
                    n_rem   = i_amount[10:0];
                    n_cbyte = '0;
                    n_cpos  = '0;
                end else begin
                    n_frm.cnt      = 4'd12;
                    n_frm.last_end = 1'b1;
                end
            end
        end
    end

    // state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit  <= mbtf_pkg::UNIT_RESET;
            r_tid   <= mbtf_pkg::TID_RESET;
            r_kind  <= mbtf_pkg::KIND_NONE;
            r_rem   <= '0;
            r_cbyte <= '0;
            r_cpos  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_unit <= i_cfg_data;
            end
            if (in_acc) begin
                r_tid   <= n_tid;
                r_kind  <= n_kind;
                r_rem   <= n_rem;
                r_cbyte <= n_cbyte;
                r_cpos  <= n_cpos;
            end
        end
    end

    // frame register and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
            r_fi <= '0;
        end else begin
            if (in_acc && n_frm.cnt != 4'd0) begin
                r_fv <= 1'b1;
                r_fi <= '0;
            end else if (r_fv && out_load) begin
                if (slot_last) begin
                    r_fv <= 1'b0;
                    r_fi <= '0;
                end else begin
                    r_fi <= r_fi + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_frm.cnt != 4'd0) begin
            r_frm <= n_frm;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_fv) begin
            r_ob <= r_frm.bytes[r_fi];
            r_oe <= r_frm.last_end && slot_last;
            r_or <= r_frm.rej;
        end
    end

    assign o_valid      = r_ov;
    assign o_frame_byte = r_ob;
    assign o_frame_end  = r_oe;
    assign o_rejected   = r_or;

    a_rej_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_or) |-> (r_oe && r_ob == 8'd0))
        else $error("rejection item malformed");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fv |-> (r_fi < r_frm.cnt))
        else $error("frame index beyond byte count");

    a_tid_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && hdr_ok && i_mode != mbtf_pkg::MODE_DATA) |=>
            (r_tid == $past(r_tid) + 16'd1))
        else $error("transaction id did not advance");

    a_idle_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind == mbtf_pkg::KIND_NONE) |-> (r_rem == 11'd0))
        else $error("items remain with no write pending");

    a_frame_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fv && !out_load) |=> (r_fv && $stable(r_fi)))
        else $error("frame moved while output stalled");

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for modbus_tcp_request_framer
// predicts the frame byte stream per request item and checks every output byte
// depends on mbtf_pkg and the framer rtl
`timescale 1ns / 100ps

module tb_top;

    localparam logic [7:0] FN_RD_COILS  = 8'd1;
    localparam logic [7:0] FN_RD_INPUTS = 8'd2;
    localparam logic [7:0] FN_RD_HOLD   = 8'd3;
    localparam logic [7:0] FN_RD_INREGS = 8'd4;

    localparam int HOLD_OFF       = 2 * mbtf_pkg::FRAME_BYTES + 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       rej;
    } t_byte_due;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [3:0]  i_mode      = '0;
    logic [15:0] i_address   = '0;
    logic [15:0] i_amount    = '0;
    logic [15:0] i_value     = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [7:0]  o_frame_byte;
    logic        o_frame_end;
    logic        o_rejected;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data  = '0;

    // framer state as the predictor sees it
    logic [7:0]      unit_id_m  = mbtf_pkg::UNIT_RESET;
    logic [15:0]     tid_m      = mbtf_pkg::TID_RESET;
    mbtf_pkg::t_kind kind_m     = mbtf_pkg::KIND_NONE;
    logic [10:0]     left_m     = '0;
    logic [7:0]      coil_acc_m = '0;
    logic [2:0]      coil_pos_m = '0;

    t_byte_due bytes_due[$];
    t_byte_due byte_exp;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int n_items       = 0;
    int n_bytes       = 0;
    int n_rejects     = 0;
    int idle_cycles   = 0;

    modbus_tcp_request_framer i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_address    (i_address),
        .i_amount     (i_amount),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_byte(input logic [7:0] data, input logic last,
                                      input logic rej);
        t_byte_due b;
        b.data = data;
        b.last = last;
        b.rej  = rej;
        bytes_due.push_back(b);
    endfunction

    function automatic void push_word(input logic [15:0] w, input logic last);
        push_byte(w[15:8], 1'b0, 1'b0);
        push_byte(w[7:0], last, 1'b0);
    endfunction

    function automatic void push_reject();
        push_byte(8'h00, 1'b1, 1'b1);
    endfunction

    // mbap header, function code and address; consumes one transaction id
    function automatic void push_head(input logic [15:0] len, input logic [7:0] fn,
                                      input logic [15:0] addr);
        push_word(tid_m, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(len, 1'b0);
        push_byte(unit_id_m, 1'b0, 1'b0);
        push_byte(fn, 1'b0, 1'b0);
        push_word(addr, 1'b0);
        tid_m = tid_m + 16'd1;
    endfunction

    function automatic void build_frame(input logic [3:0] mode, input logic [15:0] addr,
                                        input logic [15:0] amount, input logic [15:0] value);
        logic [10:0] nbytes;
        logic [7:0]  fn;
        logic        last;
        if (mode == mbtf_pkg::MODE_DATA) begin
            if (kind_m == mbtf_pkg::KIND_NONE || left_m == '0) begin
                push_reject();
            end else begin
                left_m = left_m - 11'd1;
                last   = (left_m == '0);
                if (kind_m == mbtf_pkg::KIND_REGS) begin
                    push_word(value, last);
                end else begin
                    coil_acc_m = coil_acc_m | (8'(value[0]) << coil_pos_m);
                    if (coil_pos_m == 3'd7 || last) begin
                        push_byte(coil_acc_m, last, 1'b0);
                        coil_acc_m = '0;
                        coil_pos_m = '0;
                    end else begin
                        coil_pos_m = coil_pos_m + 3'd1;
                    end
                end
                if (last) kind_m = mbtf_pkg::KIND_NONE;
            end
        end else if (mode > mbtf_pkg::MODE_DATA || kind_m != mbtf_pkg::KIND_NONE) begin
            push_reject();
        end else begin
            case (mode)
                mbtf_pkg::MODE_RD_COILS, mbtf_pkg::MODE_RD_INPUTS,
                mbtf_pkg::MODE_RD_HOLD, mbtf_pkg::MODE_RD_INREGS: begin
                    case (mode)
                        mbtf_pkg::MODE_RD_COILS:  fn = FN_RD_COILS;
                        mbtf_pkg::MODE_RD_INPUTS: fn = FN_RD_INPUTS;
                        mbtf_pkg::MODE_RD_HOLD:   fn = FN_RD_HOLD;
                        default:                  fn = FN_RD_INREGS;
                    endcase
                    if (mode <= mbtf_pkg::MODE_RD_INPUTS &&
                        amount > mbtf_pkg::DEF_MAX_READ_BITS) begin
                        push_reject();
                    end else begin
                        push_head(mbtf_pkg::LEN_SINGLE, fn, addr);
                        push_word(amount, 1'b1);
                    end
                end
                mbtf_pkg::MODE_WR_COIL: begin
                    push_head(mbtf_pkg::LEN_SINGLE, mbtf_pkg::FN_WR_COIL, addr);
                    push_word(value[0] ? mbtf_pkg::COIL_ON : 16'h0000, 1'b1);
                end
                mbtf_pkg::MODE_WR_REG: begin
                    push_head(mbtf_pkg::LEN_SINGLE, mbtf_pkg::FN_WR_REG, addr);
                    push_word(value, 1'b1);
                end
                mbtf_pkg::MODE_WR_COILS: begin
                    if (amount == '0 || amount > mbtf_pkg::DEF_MAX_WRITE_COILS) begin
                        push_reject();
                    end else begin
                        nbytes = 11'((int'(amount) + 7) / 8);
                        push_head(mbtf_pkg::LEN_MULTI + 16'(nbytes), mbtf_pkg::FN_WR_COILS,
                                  addr);
                        push_word(amount, 1'b0);
                        push_byte(nbytes[7:0], 1'b0, 1'b0);
                        kind_m     = mbtf_pkg::KIND_COILS;
                        left_m     = amount[10:0];
                        coil_acc_m = '0;
                        coil_pos_m = '0;
                    end
                end
                default: begin
                    if (amount == '0 || amount > mbtf_pkg::DEF_MAX_WRITE_REGS) begin
                        push_reject();
                    end else begin
                        nbytes = 11'(2 * int'(amount));
                        push_head(mbtf_pkg::LEN_MULTI + 16'(nbytes), mbtf_pkg::FN_WR_REGS,
                                  addr);
                        push_word(amount, 1'b0);
                        push_byte(nbytes[7:0], 1'b0, 1'b0);
                        kind_m = mbtf_pkg::KIND_REGS;
                        left_m = amount[10:0];
                    end
                end
            endcase
        end
    endfunction

    task automatic send_item(input logic [3:0] mode, input logic [15:0] addr,
                             input logic [15:0] amount, input logic [15:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_address <= addr;
        i_amount  <= amount;
        i_value   <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        build_frame(mode, addr, amount, value);
        n_items++;
    endtask

    // hold off until every predicted byte is out and the framer has gone quiet
    task automatic wait_frames_done();
        i_valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    task automatic set_unit_id(input logic [7:0] id);
        wait_frames_done();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= id;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        unit_id_m = id;
    endtask

    task automatic test_reads();
        send_item(mbtf_pkg::MODE_RD_COILS, 16'h0000, 16'd0, 16'h0000);
        send_item(mbtf_pkg::MODE_RD_COILS, 16'hFFFF, 16'(mbtf_pkg::DEF_MAX_READ_BITS),
                  16'hFFFF);
        send_item(mbtf_pkg::MODE_RD_COILS, 16'h0001, 16'(mbtf_pkg::DEF_MAX_READ_BITS + 1),
                  16'h0000);
        send_item(mbtf_pkg::MODE_RD_INPUTS, 16'h8000, 16'hFFFF, 16'h0000);
        send_item(mbtf_pkg::MODE_RD_HOLD, 16'hFFFF, 16'hFFFF, 16'($urandom));
        send_item(mbtf_pkg::MODE_RD_INREGS, 16'h5AA5, 16'd0, 16'($urandom));
    endtask

    task automatic test_single_writes();
        send_item(mbtf_pkg::MODE_WR_COIL, 16'h0000, 16'($urandom), 16'h0001);
        send_item(mbtf_pkg::MODE_WR_COIL, 16'hFFFF, 16'($urandom), 16'hFFFE);
        send_item(mbtf_pkg::MODE_WR_REG, 16'h1234, 16'($urandom), 16'h0000);
        send_item(mbtf_pkg::MODE_WR_REG, 16'hFFFF, 16'($urandom), 16'hFFFF);
    endtask

    task automatic test_multi_writes();
        send_item(mbtf_pkg::MODE_WR_REGS, 16'h0010, 16'd0, 16'h0000);
        send_item(mbtf_pkg::MODE_WR_REGS, 16'h0010, 16'(mbtf_pkg::DEF_MAX_WRITE_REGS + 1),
                  16'h0000);
        send_item(mbtf_pkg::MODE_WR_COILS, 16'h0020, 16'd0, 16'h0000);
        send_item(mbtf_pkg::MODE_WR_COILS, 16'h0020, 16'(mbtf_pkg::DEF_MAX_WRITE_COILS + 1),
                  16'h0000);
        send_item(mbtf_pkg::MODE_DATA, 16'h0000, 16'h0000, 16'hBEEF);
        send_item(4'd9, 16'($urandom), 16'($urandom), 16'($urandom));
        send_item(4'd15, 16'($urandom), 16'($urandom), 16'($urandom));
        // header while a write is pending
        send_item(mbtf_pkg::MODE_WR_REGS, 16'hABCD, 16'd1, 16'h0000);
        send_item(mbtf_pkg::MODE_RD_HOLD, 16'h0000, 16'd4, 16'h0000);
        send_item(mbtf_pkg::MODE_DATA, 16'($urandom), 16'($urandom), 16'hFFFF);
        // one full coil byte then a partial one
        send_item(mbtf_pkg::MODE_WR_COILS, 16'h00C8, 16'd9, 16'h0000);
        for (int k = 0; k < 9; k++) begin
            send_item(mbtf_pkg::MODE_DATA, 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_max_writes();
        send_item(mbtf_pkg::MODE_WR_REGS, 16'($urandom), 16'(mbtf_pkg::DEF_MAX_WRITE_REGS),
                  16'($urandom));
        for (int k = 0; k < mbtf_pkg::DEF_MAX_WRITE_REGS; k++) begin
            send_item(mbtf_pkg::MODE_DATA, 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_random_requests(input int n_target);
        int         sent;
        int unsigned pick;
        int         cnt;
        logic       is_coils;
        logic [3:0] m;
        sent = 0;
        while (sent < n_target) begin
            if ($urandom_range(24) == 0) wait_frames_done();
            pick = $urandom_range(99);
            if (pick < 25) begin
                m = 4'($urandom_range(3));
                if (m <= mbtf_pkg::MODE_RD_INPUTS && $urandom_range(3) != 0) begin
                    send_item(m, 16'($urandom),
                              16'($urandom_range(mbtf_pkg::DEF_MAX_READ_BITS)),
                              16'($urandom));
                end else begin
                    send_item(m, 16'($urandom), 16'($urandom), 16'($urandom));
                end
                sent++;
            end else if (pick < 40) begin
                send_item($urandom_range(1) ? mbtf_pkg::MODE_WR_COIL : mbtf_pkg::MODE_WR_REG,
                          16'($urandom), 16'($urandom), 16'($urandom));
                sent++;
            end else if (pick < 85) begin
                is_coils = 1'($urandom_range(1));
                cnt = is_coils ? $urandom_range(1, 20) : $urandom_range(1, 6);
                send_item(is_coils ? mbtf_pkg::MODE_WR_COILS : mbtf_pkg::MODE_WR_REGS,
                          16'($urandom), 16'(cnt), 16'($urandom));
                sent++;
                for (int k = 0; k < cnt; k++) begin
                    if ($urandom_range(19) == 0) begin
                        send_item(4'($urandom_range(7)), 16'($urandom), 16'($urandom),
                                  16'($urandom));
                        sent++;
                    end
                    send_item(mbtf_pkg::MODE_DATA, 16'($urandom), 16'($urandom),
                              16'($urandom));
                    sent++;
                end
            end else begin
                case ($urandom_range(3))
                    0: send_item(4'($urandom_range(9, 15)), 16'($urandom), 16'($urandom),
                                 16'($urandom));
                    1: send_item(mbtf_pkg::MODE_DATA, 16'($urandom), 16'($urandom),
                                 16'($urandom));
                    2: send_item($urandom_range(1) ? mbtf_pkg::MODE_WR_COILS :
                                                     mbtf_pkg::MODE_WR_REGS,
                                 16'($urandom),
                                 $urandom_range(1) ? 16'd0 : 16'($urandom_range(1969, 65535)),
                                 16'($urandom));
                    default: send_item(4'($urandom_range(1)), 16'($urandom),
                                       16'($urandom_range(mbtf_pkg::DEF_MAX_READ_BITS + 1,
                                                          65535)),
                                       16'($urandom));
                endcase
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            n_bytes++;
            if (bytes_due.size() == 0) begin
                $error("unexpected frame byte %02h end %0b rejected %0b",
                       o_frame_byte, o_frame_end, o_rejected);
                fail_count++;
            end else begin
                byte_exp = bytes_due.pop_front();
                if (byte_exp.rej) n_rejects++;
                if (o_frame_byte !== byte_exp.data) begin
                    $error("frame_byte: expected %02h, got %02h", byte_exp.data, o_frame_byte);
                    fail_count++;
                end
                if (o_frame_end !== byte_exp.last) begin
                    $error("frame_end: expected %0b, got %0b", byte_exp.last, o_frame_end);
                    fail_count++;
                end
                if (o_rejected !== byte_exp.rej) begin
                    $error("rejected: expected %0b, got %0b", byte_exp.rej, o_rejected);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d bytes outstanding",
                     idle_cycles, bytes_due.size());
            $display("modbus_tcp_request_framer regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 64;
        test_reads();
        test_single_writes();
        test_multi_writes();
        test_random_requests(55);

        set_unit_id(8'h00);
        send_idle_pct = 64;
        recv_idle_pct = 11;
        test_random_requests(55);

        set_unit_id(8'hFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_requests(55);

        set_unit_id(8'($urandom_range(2, 254)));
        test_max_writes();
        wait_frames_done();

        $display("%0d request items, %0d frame bytes checked, %0d rejections",
                 n_items, n_bytes, n_rejects);
        $display("unit ids 1, 0, 255 and random; longest register write; range rejections");
        if (fail_count == 0) begin
            $display("modbus_tcp_request_framer regression: pass");
        end else begin
            $display("modbus_tcp_request_framer regression: fail");
        end
        $finish;
    end

endmodule
